FILE: rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window minimiser
// Window geometry, register map, cell chain structs and helper functions.
// ----------------------------------------------------------------------------
package swm_pkg;

	// window geometry
	localparam int MAX_WINDOW = 64;
	localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

	// field widths
	localparam int KMER_W = 32;
	localparam int POS_W  = 32;
	localparam int ORD_W  = 32;
	localparam int CFG_W  = 7;

	// register map
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_WINDOW_KMERS = 1'b0;
	localparam logic [CFG_W-1:0] WINDOW_KMERS_RESET = CFG_W'(8);

	// control broadcast to every cell
	typedef struct packed {
		logic             load;
		logic             shift;
		logic [IDX_W-1:0] tgt;
		logic [CNT_W-1:0] win;
	} swm_ctrl_t;

	// running leftmost minimum handed along the chain
	typedef struct packed {
		logic              valid;
		logic [KMER_W-1:0] value;
		logic [IDX_W-1:0]  index;
	} swm_scan_t;

	// one result beat
	typedef struct packed {
		logic [KMER_W-1:0] value;
		logic [POS_W-1:0]  position;
		logic [ORD_W-1:0]  ordinal;
	} swm_result_t;

	// zero acts as one, oversize saturates at the chain length
	function automatic logic [CNT_W-1:0] eff_window(input logic [CFG_W-1:0] cfg);
		int unsigned c;
		c = int'(cfg);
		if (c == 0)
			return CNT_W'(1);
		else if (c > MAX_WINDOW)
			return CNT_W'(MAX_WINDOW);
		else
			return CNT_W'(c);
	endfunction

endpackage

FILE: rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell: one window slot of the minimiser chain
// Holds one k-mer, shifts towards the head, and folds its entry into the
// running leftmost minimum passing through it.
// ----------------------------------------------------------------------------
module swm_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [swm_pkg::IDX_W-1:0] cell_idx,
	input  swm_pkg::swm_ctrl_t        ctrl,
	input  logic [swm_pkg::KMER_W-1:0] kmer,
	input  logic [swm_pkg::KMER_W-1:0] right_entry,
	output logic [swm_pkg::KMER_W-1:0] entry,
	input  swm_pkg::swm_scan_t        scan_in,
	output swm_pkg::swm_scan_t        scan_out
);
	import swm_pkg::*;

	logic [KMER_W-1:0] entry_q;
	logic              scan_valid_q;
	logic [KMER_W-1:0] scan_value_q;
	logic [IDX_W-1:0]  scan_index_q;
	logic              active;
	logic              take;

	// slot storage: load at the target, shift the rest towards the head
	always_ff @(posedge clk) begin
		if (ctrl.load && (cell_idx == ctrl.tgt)) begin
			entry_q <= kmer;
		end else if (ctrl.shift && (cell_idx < ctrl.tgt)) begin
			entry_q <= right_entry;
		end
	end

	// only slots inside the window take part in the minimum
	assign active = (CNT_W'(cell_idx) < ctrl.win);
	assign take   = active && (entry_q < scan_in.value);

	// scan stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_valid_q <= 1'b0;
		end else begin
			scan_valid_q <= scan_in.valid;
		end
	end

	// scan stage payload, strictly smaller keeps the leftmost
	always_ff @(posedge clk) begin
		if (take) begin
			scan_value_q <= entry_q;
			scan_index_q <= cell_idx;
		end else begin
			scan_value_q <= scan_in.value;
			scan_index_q <= scan_in.index;
		end
	end

	assign entry    = entry_q;
	assign scan_out = {scan_valid_q, scan_value_q, scan_index_q};

endmodule

FILE: rtl/swm_out_queue.sv
// ----------------------------------------------------------------------------
// swm_out_queue: two-entry result buffer
// Output register with a skid slot so a new item can enter while a result
// beat waits on a stalled output.
// ----------------------------------------------------------------------------
module swm_out_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  swm_pkg::swm_result_t push_data,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_stall,
	output swm_pkg::swm_result_t out_data
);
	import swm_pkg::*;

	logic        head_v_q;
	logic        skid_v_q;
	swm_result_t head_q;
	swm_result_t skid_q;
	logic        pop;

	assign pop = head_v_q && !out_stall;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= push;
			end else begin
				head_v_q <= push;
			end
		end else if (!head_v_q) begin
			head_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				head_q <= skid_q;
				skid_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end else if (!head_v_q) begin
			head_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_v_q;
	assign out_valid = head_v_q;
	assign out_data  = head_q;

endmodule

FILE: rtl/sliding_window_minimizer_core.sv
// A beat that emits without a rescan is pushed into the result buffer as it is accepted.
// Throughput: one k-mer per cycle while no rescan runs and the result buffer is not full.
// A rescan runs the running minimum down the 64-cell chain, one cell per cycle, from the start register
// through every cell register, with input stalled until the result is pushed into the result buffer.
// Reset: counters, current minimum, window length (8) and queue cleared; window slots undefined.
// ----------------------------------------------------------------------------
// sliding_window_minimizer_core: k-mer window minimiser
// Chain of window cells with a systolic leftmost-minimum scan, control
// logic, configuration port and a two-entry result buffer.
// ----------------------------------------------------------------------------
module sliding_window_minimizer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [swm_pkg::KMER_W-1:0]  kmer_value,
	input  logic                        seq_start,
	// output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [swm_pkg::KMER_W-1:0]  min_value,
	output logic [swm_pkg::POS_W-1:0]   min_position,
	output logic [swm_pkg::ORD_W-1:0]   min_ordinal,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swm_pkg::PADDR_W-1:0] paddr,
	input  logic [swm_pkg::PDATA_W-1:0] pwdata,
	output logic [swm_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import swm_pkg::*;

	// configuration
	logic [CFG_W-1:0] window_kmers_q;
	logic             cfg_write;

	// control state
	logic [CNT_W-1:0]  fill_q;
	logic [KMER_W-1:0] cur_min_q;
	logic [POS_W-1:0]  kc_q;
	logic [ORD_W-1:0]  ec_q;
	logic              scanning_q;
	logic              scan_start_q;
	logic [POS_W-1:0]  base_q;

	// per-beat working values
	logic              accept;
	logic [CNT_W-1:0]  win;
	logic [CNT_W-1:0]  fill_eff;
	logic [CNT_W-1:0]  fill_next;
	logic [KMER_W-1:0] cur_min_eff;
	logic [POS_W-1:0]  kc_eff;
	logic [ORD_W-1:0]  ec_eff;
	logic              filling;
	logic              start_scan;
	logic              direct_emit;

	// chain
	swm_ctrl_t         ctrl;
	logic [KMER_W-1:0] entries  [MAX_WINDOW];
	logic [KMER_W-1:0] right_of [MAX_WINDOW];
	swm_scan_t         scan_bus [MAX_WINDOW+1];
	swm_scan_t         scan_res;

	// result queue
	logic        q_push;
	swm_result_t q_push_data;
	logic        q_full;
	swm_result_t q_out;

	// register write and read-back
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_kmers_q <= WINDOW_KMERS_RESET;
		end else if (cfg_write && (paddr[2] == REG_WINDOW_KMERS)) begin
			window_kmers_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WINDOW_KMERS: prdata = PDATA_W'(window_kmers_q);
			default:          prdata = '0;
		endcase
	end

	// input handshake: hold off during a rescan or when the buffer is full
	assign in_stall = scanning_q || q_full;
	assign accept   = in_valid && !in_stall;

	// sequence start clears state ahead of this k-mer
	assign win         = eff_window(window_kmers_q);
	assign cur_min_eff = seq_start ? '0 : cur_min_q;
	assign kc_eff      = seq_start ? '0 : kc_q;
	assign ec_eff      = seq_start ? '0 : ec_q;

	always_comb begin
		if (seq_start)
			fill_eff = '0;
		else if (fill_q > win)
			fill_eff = win;
		else
			fill_eff = fill_q;
	end

	assign filling   = (fill_eff < win);
	assign fill_next = fill_eff + CNT_W'(1);

	// rescan on completion of the window or when the minimum leaves, else emit a new smaller k-mer directly
	always_comb begin
		start_scan  = 1'b0;
		direct_emit = 1'b0;
		if (filling) begin
			start_scan = (fill_next == win);
		end else if (cur_min_eff == entries[0]) begin
			start_scan = 1'b1;
		end else if (kmer_value < cur_min_eff) begin
			direct_emit = 1'b1;
		end
	end

	// control broadcast to the chain
	always_comb begin
		ctrl.load  = accept;
		ctrl.shift = accept && !filling;
		ctrl.win   = win;
		if (filling)
			ctrl.tgt = fill_eff[IDX_W-1:0];
		else
			ctrl.tgt = IDX_W'(win - CNT_W'(1));
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			cur_min_q    <= '0;
			kc_q         <= '0;
			ec_q         <= '0;
			scanning_q   <= 1'b0;
			scan_start_q <= 1'b0;
		end else begin
			scan_start_q <= accept && start_scan;
			if (accept) begin
				kc_q <= kc_eff + POS_W'(1);
				if (filling) begin
					fill_q <= fill_next;
				end else begin
					fill_q <= fill_eff;
				end
				if (start_scan) begin
					scanning_q <= 1'b1;
					cur_min_q  <= cur_min_eff;
					ec_q       <= ec_eff;
				end else if (direct_emit) begin
					cur_min_q <= kmer_value;
					ec_q      <= ec_eff + ORD_W'(1);
				end else begin
					cur_min_q <= cur_min_eff;
					ec_q      <= ec_eff;
				end
			end else if (scan_res.valid) begin
				scanning_q <= 1'b0;
				cur_min_q  <= scan_res.value;
				ec_q       <= ec_q + ORD_W'(1);
			end
		end
	end

	// position of window slot zero for the pending rescan
	always_ff @(posedge clk) begin
		if (accept && start_scan) begin
			base_q <= kc_eff - POS_W'(win) + POS_W'(1);
		end
	end

	// chain of window cells
	assign scan_bus[0] = {scan_start_q, entries[0], IDX_W'(0)};

	for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
		if (g == MAX_WINDOW - 1) begin : g_tail
			assign right_of[g] = '0;
		end else begin : g_body
			assign right_of[g] = entries[g+1];
		end

		swm_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cell_idx    (IDX_W'(g)),
			.ctrl        (ctrl),
			.kmer        (kmer_value),
			.right_entry (right_of[g]),
			.entry       (entries[g]),
			.scan_in     (scan_bus[g]),
			.scan_out    (scan_bus[g+1])
		);
	end

	assign scan_res = scan_bus[MAX_WINDOW];

	// result beat: rescan result or a new smaller k-mer
	always_comb begin
		q_push = scan_res.valid || (accept && direct_emit);
		if (scan_res.valid) begin
			q_push_data.value    = scan_res.value;
			q_push_data.position = base_q + POS_W'(scan_res.index);
			q_push_data.ordinal  = ec_q;
		end else begin
			q_push_data.value    = kmer_value;
			q_push_data.position = kc_eff;
			q_push_data.ordinal  = ec_eff;
		end
	end

	swm_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (q_out)
	);

	assign min_value    = q_out.value;
	assign min_position = q_out.position;
	assign min_ordinal  = q_out.ordinal;

endmodule

FILE: sim/tb_sliding_window_minimizer_core.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_minimizer_core: self-checking bench of the window minimiser
// Drives k-mer beats with random gaps and result stalls. A behavioural copy
// of the window predicts every minimiser not written out in a directed row. Directed rows run first, then
// random sequences across a sweep of window lengths set over the APB port.
// ----------------------------------------------------------------------------
module tb_sliding_window_minimizer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import swm_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_WINDOW_KMERS = PADDR_W'(4 * int'(REG_WINDOW_KMERS));
	// a rescan walks the whole chain before its result lands
	localparam int RESCAN_SLACK = MAX_WINDOW + 16;
	localparam int N_PLAN = 10;
	localparam logic [CFG_W-1:0] WINDOW_PLAN [N_PLAN] = '{
		7'd1, 7'd0, 7'd3, 7'd64, 7'd5, 7'd127, 7'd2, 7'd16, 7'd100, 7'd8
	};

	// one directed row, with the result written out where it is obvious
	typedef struct packed {
		logic [KMER_W-1:0] kmer;
		logic              start;
		logic              typed;
		logic              emits;
		swm_result_t       res;
	} stim_row_t;

	localparam int N_DIRECTED = 25;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, '0},
		'{32'h0000_0010, 1'b0, 1'b1, 1'b0, '0},
		'{32'h0000_0020, 1'b0, 1'b1, 1'b0, '0},
		'{32'h0000_0030, 1'b0, 1'b1, 1'b0, '0},
		'{32'h0000_0040, 1'b0, 1'b1, 1'b0, '0},
		'{32'h0000_0050, 1'b0, 1'b1, 1'b0, '0},
		'{32'h0000_0060, 1'b0, 1'b1, 1'b0, '0},
		'{32'h0000_0070, 1'b0, 1'b1, 1'b1, '{32'h10, 32'd1, 32'd0}},
		'{32'h0000_0008, 1'b0, 1'b1, 1'b1, '{32'h08, 32'd8, 32'd1}},
		'{32'h0000_0000, 1'b0, 1'b1, 1'b1, '{32'h00, 32'd9, 32'd2}},
		'{32'h0000_0000, 1'b0, 1'b1, 1'b0, '0},
		'{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, '0},
		'{32'h0000_0003, 1'b0, 1'b0, 1'b0, '0},
		'{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, '0},
		'{32'h0000_0005, 1'b1, 1'b1, 1'b0, '0},
		'{32'h0000_0004, 1'b0, 1'b1, 1'b0, '0},
		'{32'h0000_00AA, 1'b1, 1'b0, 1'b0, '0},
		'{32'h0000_00AA, 1'b0, 1'b0, 1'b0, '0},
		'{32'h0000_00AA, 1'b0, 1'b0, 1'b0, '0},
		'{32'h0000_00AA, 1'b0, 1'b0, 1'b0, '0},
		'{32'h0000_00AA, 1'b0, 1'b0, 1'b0, '0},
		'{32'h0000_00AA, 1'b0, 1'b0, 1'b0, '0},
		'{32'h0000_00AA, 1'b0, 1'b0, 1'b0, '0},
		'{32'h0000_00AA, 1'b0, 1'b0, 1'b0, '0},
		'{32'h0000_00AA, 1'b0, 1'b0, 1'b0, '0}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [KMER_W-1:0]   kmer_value = '0;
	logic                seq_start = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [KMER_W-1:0]   min_value;
	logic [POS_W-1:0]    min_position;
	logic [ORD_W-1:0]    min_ordinal;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// predictor state: window copy, fill level, counters, register
	logic [KMER_W-1:0]   win_copy [MAX_WINDOW];
	int unsigned         held;
	logic [KMER_W-1:0]   cur_min;
	logic [POS_W-1:0]    next_pos;
	logic [ORD_W-1:0]    emitted;
	logic [CFG_W-1:0]    cfg_window;

	swm_result_t         expected_minimizers [$];
	int unsigned         mismatches = 0;
	int unsigned         minimizers_seen = 0;
	bit                  quiet = 1'b0;

	sliding_window_minimizer_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kmer_value   (kmer_value),
		.seq_start    (seq_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.min_value    (min_value),
		.min_position (min_position),
		.min_ordinal  (min_ordinal),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// overall time limit
	initial begin
		#5_000_000;
		$display("sliding_window_minimizer_core test failed");
		$finish;
	end

	// append one predicted minimiser to the pending list
	function automatic void add_expected(input swm_result_t r);
		expected_minimizers.insert(expected_minimizers.size(), r);
	endfunction

	// advance the window copy by one k-mer; returns 1 when a minimiser is emitted
	function automatic bit predict_minimizer(input logic [KMER_W-1:0] kmer, input logic start,
			output swm_result_t res);
		int unsigned       w;
		int unsigned       best;
		logic [KMER_W-1:0] leaving;
		logic [POS_W-1:0]  here;
		bit                rescan;
		bit                hit;
		w = (cfg_window == 0) ? 1 : (cfg_window > MAX_WINDOW) ? MAX_WINDOW : int'(cfg_window);
		res = '0;
		rescan = 1'b0;
		hit = 1'b0;
		best = 0;
		if (start) begin
			held = 0;
			cur_min = '0;
			next_pos = '0;
			emitted = '0;
		end
		// a shrunk window keeps its oldest entries
		if (held > w)
			held = w;
		here = next_pos;
		if (held < w) begin
			win_copy[held] = kmer;
			held++;
			rescan = (held == w);
		end else begin
			leaving = win_copy[0];
			for (int j = 0; j + 1 < w; j++)
				win_copy[j] = win_copy[j + 1];
			win_copy[w - 1] = kmer;
			if (cur_min == leaving) begin
				rescan = 1'b1;
			end else if (kmer < cur_min) begin
				cur_min = kmer;
				res = '{value: kmer, position: here, ordinal: emitted};
				hit = 1'b1;
			end
		end
		// leftmost minimum of the full window
		if (rescan) begin
			for (int j = 1; j < w; j++)
				if (win_copy[j] < win_copy[best])
					best = j;
			cur_min = win_copy[best];
			res = '{value: cur_min, position: POS_W'(best) + here - POS_W'(w - 1),
				ordinal: emitted};
			hit = 1'b1;
		end
		if (hit)
			emitted++;
		next_pos++;
		return hit;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s: expected %h, got %h", what, want, got);
	endtask

	// offer one beat and hold it until accepted
	task automatic send_kmer(input logic [KMER_W-1:0] kmer, input logic start);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid <= 1'b1;
		kmer_value <= kmer;
		seq_start <= start;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic stop_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// wait for every pending minimiser, then for any rescan still in flight
	task automatic settle();
		while (expected_minimizers.size() != 0)
			@(posedge clk);
		repeat (RESCAN_SLACK) @(posedge clk);
	endtask

	// write the window length, then read it back
	task automatic write_window(input logic [CFG_W-1:0] value);
		logic [PDATA_W-1:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_WINDOW_KMERS;
		pwdata <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd[CFG_W-1:0] !== value)
			note_mismatch("window_kmers read-back", 32'(value), rd);
		cfg_window = value;
	endtask

	// result stalls in random bursts
	initial begin
		int unsigned hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(0, 4);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// compare each result beat with the oldest pending minimiser
	always @(posedge clk) begin
		swm_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			minimizers_seen++;
			if (expected_minimizers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("minimiser with none pending: value %h position %0d ordinal %0d",
						min_value, min_position, min_ordinal);
			end else begin
				want = expected_minimizers[0];
				expected_minimizers.delete(0);
				if (min_value !== want.value)
					note_mismatch("min_value", want.value, min_value);
				if (min_position !== want.position)
					note_mismatch("min_position", want.position, min_position);
				if (min_ordinal !== want.ordinal)
					note_mismatch("min_ordinal", want.ordinal, min_ordinal);
			end
		end
	end

	// stimulus
	initial begin
		swm_result_t       res;
		bit                hit;
		logic [KMER_W-1:0] kmer;
		logic              start;
		int unsigned       n_items;
		int unsigned       n_random;

		foreach (win_copy[j])
			win_copy[j] = '0;
		held = 0;
		cur_min = '0;
		next_pos = '0;
		emitted = '0;
		cfg_window = WINDOW_KMERS_RESET;
		n_random = 0;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// directed rows at the reset window length
		for (int r = 0; r < N_DIRECTED; r++) begin
			send_kmer(DIRECTED[r].kmer, DIRECTED[r].start);
			hit = predict_minimizer(DIRECTED[r].kmer, DIRECTED[r].start, res);
			if (DIRECTED[r].typed) begin
				if (DIRECTED[r].emits)
					add_expected(DIRECTED[r].res);
			end else if (hit) begin
				add_expected(res);
			end
		end
		stop_input();

		// random sequences over a sweep of window lengths
		for (int p = 0; p < N_PLAN; p++) begin
			settle();
			write_window(WINDOW_PLAN[p]);
			quiet = (p == N_PLAN - 1) || ($urandom_range(0, 3) == 0);
			n_items = (WINDOW_PLAN[p] >= 32) ? 70 : 25;
			for (int n = 0; n < n_items; n++) begin
				// spread values so ties and window-exit rescans are frequent
				case ($urandom_range(0, 3))
					0: kmer = $urandom;
					1: kmer = $urandom_range(0, 7);
					2: kmer = 32'hFFFF_FFFF - $urandom_range(0, 7);
					default: kmer = $urandom_range(0, 255);
				endcase
				// a new phase may resume the old sequence at the new length
				if (n == 0)
					start = 1'($urandom_range(0, 1));
				else
					start = ($urandom_range(0, 39) == 0);
				send_kmer(kmer, start);
				if (predict_minimizer(kmer, start, res))
					add_expected(res);
				n_random++;
			end
			stop_input();
		end

		settle();
		if (expected_minimizers.size() != 0) begin
			mismatches++;
			$display("%0d minimisers never arrived", expected_minimizers.size());
		end

		$display("ran %0d directed and %0d random k-mers over %0d window lengths",
			N_DIRECTED, n_random, N_PLAN);
		$display("checked %0d minimisers, %0d mismatches", minimizers_seen, mismatches);
		if (mismatches == 0)
			$display("sliding_window_minimizer_core test passed");
		else
			$display("sliding_window_minimizer_core test failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_out_queue.sv
rtl/sliding_window_minimizer_core.sv
sim/tb_sliding_window_minimizer_core.sv
